// ===== hdl/fra_pkg.sv =====
// ----------------------------------------------------------------------------
// Fraction arithmetic package
// Shared codes and types for the fraction arithmetic and reduction core.
// ----------------------------------------------------------------------------
package fra_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO      = 2'd1,
    ST_DEN_ZERO  = 2'd2,
    ST_NUM_ZERO  = 2'd3
  } status_e;

  // Status of the reduction unit as seen by the sequencer above it.
  typedef struct packed {
    logic busy;
    logic done;
  } red_stat_t;

endpackage

// ===== hdl/fraction_arith_reduce_core.sv =====
// ----------------------------------------------------------------------------
// Fraction arithmetic core
// Adds, subtracts, multiplies or divides two signed fractions and reduces
// the result by the GCD of numerator and denominator.
// ----------------------------------------------------------------------------
// Sequence from request to result: a rejected operand goes straight to the
// result strobe. Otherwise the core runs the three multiplies and the combine,
// ending there on a zero sum or difference, then the binary GCD steps, the two
// restoring divides on the shared subtractor and the handoff back to the core.
// busy_o stays high meanwhile; a new request is taken the cycle after the strobe.
// Reset clears the sequencer and the strobe; payload registers are not reset.
module fraction_arith_reduce_core
  import fra_pkg::*;
#(
  parameter int unsigned OPERAND_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         operation_i,
  input  logic signed [15:0] x_num_i,
  input  logic signed [15:0] x_den_i,
  input  logic signed [15:0] y_num_i,
  input  logic signed [15:0] y_den_i,
  output logic               valid_o,
  output logic [1:0]         status_o,
  output logic               negative_o,
  output logic [31:0]        num_mag_o,
  output logic [30:0]        den_mag_o
);

  localparam int unsigned B  = OPERAND_BITS;
  localparam int unsigned PW = 2 * B;
  localparam int unsigned NW = 2 * B + 1;
  localparam int unsigned MW = 2 * B;
  localparam logic [1:0] MulLast = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_COMB = 5'b00100,
    S_RED  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e  state_q, state_d;
  op_e     op_q;
  status_e status_q;
  logic signed [B-1:0]  xn_q, xd_q, yn_q, yd_q;
  logic signed [PW-1:0] p_q [3];
  logic [1:0]           mstep_q;
  logic                 neg_q;
  logic [31:0]          num_q;
  logic [30:0]          den_q;

  // Operand fields: each port zero-extended to 32 bits, then its low OPERAND_BITS bits.
  logic [31:0] xn_raw, xd_raw, yn_raw, yd_raw;
  logic signed [B-1:0] xn_in, xd_in, yn_in, yd_in;
  assign xn_raw = {16'b0, x_num_i};
  assign xd_raw = {16'b0, x_den_i};
  assign yn_raw = {16'b0, y_num_i};
  assign yd_raw = {16'b0, y_den_i};
  assign xn_in  = xn_raw[B-1:0];
  assign xd_in  = xd_raw[B-1:0];
  assign yn_in  = yn_raw[B-1:0];
  assign yd_in  = yd_raw[B-1:0];

  logic accept;
  assign accept = start_i && (state_q == S_IDLE);

  // Single multiplier, stepped over the three cross products.
  logic signed [B-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] prod;
  always_comb begin
    mul_a = xn_q;
    mul_b = yd_q;
    unique case (mstep_q)
      2'd0: begin
        mul_a = xn_q;
        mul_b = (op_q == OP_MUL) ? yn_q : yd_q;
      end
      2'd1: begin
        mul_a = yn_q;
        mul_b = xd_q;
      end
      default: begin
        mul_a = xd_q;
        mul_b = (op_q == OP_DIV) ? yn_q : yd_q;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  logic signed [NW-1:0] n_sum, n_abs, d_ext, d_abs;
  logic [MW-1:0] nm, dm;
  always_comb begin
    unique case (op_q)
      OP_ADD:  n_sum = NW'(p_q[0]) + NW'(p_q[1]);
      OP_SUB:  n_sum = NW'(p_q[0]) - NW'(p_q[1]);
      default: n_sum = NW'(p_q[0]);
    endcase
  end
  assign n_abs = n_sum[NW-1] ? -n_sum : n_sum;
  assign d_ext = NW'(p_q[2]);
  assign d_abs = d_ext[NW-1] ? -d_ext : d_ext;
  assign nm    = n_abs[MW-1:0];
  assign dm    = d_abs[MW-1:0];

  logic      red_start;
  red_stat_t red_stat;
  logic [MW-1:0] red_num, red_den;
  logic [63:0]   num_wide, den_wide;

  assign red_start = (state_q == S_COMB) && (n_sum != '0);

  fra_reduce #(
    .MAG_BITS (MW)
  ) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (red_start),
    .nm_i    (nm),
    .dm_i    (dm),
    .stat_o  (red_stat),
    .num_q_o (red_num),
    .den_q_o (red_den)
  );

  assign num_wide = 64'(red_num);
  assign den_wide = 64'(red_den);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (xd_in == '0 || yd_in == '0 || xn_in == '0 || yn_in == '0) begin
            state_d = S_OUT;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL:   if (mstep_q == MulLast) state_d = S_COMB;
      S_COMB:  state_d = (n_sum == '0) ? S_OUT : S_RED;
      S_RED:   if (red_stat.done) state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mstep_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        mstep_q <= '0;
      end else if (state_q == S_MUL) begin
        mstep_q <= mstep_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(operation_i);
      xn_q  <= xn_in;
      xd_q  <= xd_in;
      yn_q  <= yn_in;
      yd_q  <= yd_in;
      neg_q <= 1'b0;
      num_q <= '0;
      den_q <= '0;
      priority if (xd_in == '0 || yd_in == '0) begin
        status_q <= ST_DEN_ZERO;
      end else if (xn_in == '0 || yn_in == '0) begin
        status_q <= ST_NUM_ZERO;
      end else begin
        status_q <= ST_OK;
      end
    end
    if (state_q == S_MUL) begin
      p_q[mstep_q] <= prod;
    end
    if (state_q == S_COMB) begin
      if (n_sum == '0) begin
        status_q <= ST_ZERO;
      end else begin
        neg_q <= n_sum[NW-1] ^ p_q[2][PW-1];
      end
    end
    if (state_q == S_RED && red_stat.done) begin
      num_q <= num_wide[31:0];
      den_q <= den_wide[30:0];
    end
  end

  assign busy_o     = (state_q != S_IDLE);
  assign valid_o    = (state_q == S_OUT);
  assign status_o   = status_q;
  assign negative_o = neg_q;
  assign num_mag_o  = num_q;
  assign den_mag_o  = den_q;

  // A request keeps the core busy through the cycle after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy_o)
    else $error("core not busy after accepted request");

  // The result strobe lasts one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  // Rejected or zero results carry no magnitude and no sign.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != ST_OK) |->
      (num_mag_o == '0 && den_mag_o == '0 && !negative_o))
    else $error("non-ok result with nonzero payload");

  // The reduction unit only runs while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_stat.busy |-> (state_q == S_RED))
    else $error("reduction unit busy outside the reduce phase");

endmodule

// ===== hdl/fra_reduce.sv =====
// ----------------------------------------------------------------------------
// Fraction reduction unit
// Finds the GCD of two nonzero magnitudes with the binary method, then
// divides both by it with a restoring divider. One subtractor serves all.
// ----------------------------------------------------------------------------
module fra_reduce
  import fra_pkg::*;
#(
  parameter int unsigned MAG_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [MAG_BITS-1:0] nm_i,
  input  logic [MAG_BITS-1:0] dm_i,
  output red_stat_t           stat_o,
  output logic [MAG_BITS-1:0] num_q_o,
  output logic [MAG_BITS-1:0] den_q_o
);

  localparam int unsigned MW = MAG_BITS;
  localparam int unsigned KW = $clog2(MW + 1);
  localparam int unsigned CW = $clog2(MW);
  localparam logic [CW-1:0] CntLast = CW'(MW - 1);

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_GCD  = 3'b010,
    R_DIV  = 3'b100
  } red_state_e;

  red_state_e state_q, state_d;
  logic [MW-1:0] a_q, a_d, b_q, b_d;
  logic [MW-1:0] nm_q, nm_d, dm_q, dm_d;
  logic [MW-1:0] g_q, g_d;
  logic [MW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [MW-1:0] nq_q, nq_d, dq_q, dq_d;
  logic [KW-1:0] k_q, k_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          sel_q, sel_d;
  logic          done_q, done_d;

  logic [MW:0]   sub_lhs, sub_rhs, sub_res;
  logic          borrow;
  logic [MW:0]   trial;
  logic [MW-1:0] quo_next;

  assign trial = {rem_q, quo_q[MW-1]};

  // The one shared subtractor: a - b during the GCD, trial - g while dividing.
  always_comb begin
    sub_lhs = '0;
    sub_rhs = '0;
    unique case (state_q)
      R_GCD: begin
        sub_lhs = {1'b0, a_q};
        sub_rhs = {1'b0, b_q};
      end
      R_DIV: begin
        sub_lhs = trial;
        sub_rhs = {1'b0, g_q};
      end
      default: begin
        sub_lhs = '0;
        sub_rhs = '0;
      end
    endcase
  end

  assign sub_res  = sub_lhs - sub_rhs;
  assign borrow   = sub_res[MW];
  assign quo_next = {quo_q[MW-2:0], ~borrow};

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    nm_d    = nm_q;
    dm_d    = dm_q;
    g_d     = g_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    nq_d    = nq_q;
    dq_d    = dq_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    done_d  = 1'b0;
    unique case (state_q)
      R_IDLE: begin
        if (start_i) begin
          a_d     = nm_i;
          b_d     = dm_i;
          nm_d    = nm_i;
          dm_d    = dm_i;
          k_d     = '0;
          state_d = R_GCD;
        end
      end
      R_GCD: begin
        priority if (a_q == b_q) begin
          // Common power of two is restored here.
          g_d     = a_q << k_q;
          quo_d   = nm_q;
          rem_d   = '0;
          cnt_d   = CntLast;
          sel_d   = 1'b0;
          state_d = R_DIV;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + KW'(1);
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (borrow) begin
          // Both odd and a below b: swap so the next step subtracts forward.
          a_d = b_q;
          b_d = a_q;
        end else begin
          a_d = {1'b0, sub_res[MW-1:1]};
        end
      end
      R_DIV: begin
        rem_d = borrow ? trial[MW-1:0] : sub_res[MW-1:0];
        quo_d = quo_next;
        if (cnt_q == '0) begin
          if (!sel_q) begin
            nq_d  = quo_next;
            quo_d = dm_q;
            rem_d = '0;
            cnt_d = CntLast;
            sel_d = 1'b1;
          end else begin
            dq_d    = quo_next;
            done_d  = 1'b1;
            state_d = R_IDLE;
          end
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      default: state_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      done_q  <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    nm_q  <= nm_d;
    dm_q  <= dm_d;
    g_q   <= g_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    nq_q  <= nq_d;
    dq_q  <= dq_d;
    k_q   <= k_d;
    cnt_q <= cnt_d;
  end

  assign stat_o.busy = (state_q != R_IDLE);
  assign stat_o.done = done_q;
  assign num_q_o     = nq_q;
  assign den_q_o     = dq_q;

endmodule
